@@ hw/rtl/ptm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types, codes and constants of the four-level page table mapper.
// ----------------------------------------------------------------------------
package ptm_pkg;

    // pool size default
    localparam int NUM_PAGES_DEF = 64;

    // table geometry and entry format
    localparam int SLOT_W     = 9;
    localparam int ENTRIES    = 512;
    localparam int FRAME_W    = 40;
    localparam int ENTRY_W    = 52;
    localparam int VPN_W      = 36;
    localparam int PAGE_SHIFT = 12;

    localparam logic [ENTRY_W-1:0] FLAG_P = 52'h1;
    localparam logic [ENTRY_W-1:0] FLAG_W = 52'h2;
    localparam logic [ENTRY_W-1:0] FLAG_U = 52'h4;

    // operation codes
    localparam logic [1:0] OP_MAP       = 2'd0;
    localparam logic [1:0] OP_MAP_FRESH = 2'd1;
    localparam logic [1:0] OP_KROOT     = 2'd2;
    localparam logic [1:0] OP_CLONE     = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // config register index (address bit 3)
    localparam logic REG_POOL_BASE = 1'b0;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         root_page;
        logic [VPN_W-1:0]   virtual_page;
        logic [FRAME_W-1:0] frame;
        logic               user;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         page_index;
        logic [ENTRY_W-1:0] leaf_entry;
        logic [6:0]         pages_used;
    } out_item_t;

    typedef enum logic [1:0] {
        ADDR_WALK,
        ADDR_NEW,
        ADDR_KROOT
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_LINK,
        WD_LEAF,
        WD_COPY
    } wdata_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load_item;
        logic       start_walk;
        logic       alloc;
        logic       set_kroot;
        logic       set_pidx;
        logic       use_fresh;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       mem_rd;
        logic       mem_wr;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       entry_from_mem;
        logic       entry_from_link;
        logic       step;
        logic       set_status;
        logic [1:0] status_code;
        logic       set_leaf;
        logic       emit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       root_bad;
        logic       pool_full;
        logic       kroot_bad;
        logic       present;
        logic       link_bad;
        logic       cnt_last;
        logic       level_one;
        logic       out_free;
    } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/four_level_page_table_mapper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// Builds four-level page tables in an internal pool of 512-entry pages.
// ----------------------------------------------------------------------------
// One item is handled at a time; a result transfer that waits in the output
// register does not hold off the next input transfer. All table work goes
// through one single-port table memory, so each page allocation but a clone
// costs a clear pass over its 512 entries. A map whose tables all exist goes
// through the check, three read/link levels, leaf write, result and idle;
// each table it creates adds a clear pass, and a fresh-page map adds one more
// clear. Making the kernel root takes one clear pass, and a clone one read
// and one write per copied entry. Errors found at the check go straight to
// the result; errors found during a walk end it at that level.
// pool_base_frame sits at byte address 0 of the 64-bit config port.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper
    import ptm_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    ptm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // tables, allocator and result register
    ptm_dpath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // an accepted transfer makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // failed operations report no page and no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |->
        (out_data.page_index == '0) && (out_data.leaf_entry == '0))
        else $error("error result carries data");

    // allocator never passes the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(out_data.pages_used) <= NUM_PAGES)
        else $error("pool overrun");

endmodule
`default_nettype wire

@@ hw/rtl/ptm_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_dpath
// Table memory, allocator, walk registers, config register and result register.
// ----------------------------------------------------------------------------
module ptm_dpath
    import ptm_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]    prdata,
    output logic           pready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data,
    input  wire cmd_t      cmd,
    output stat_t          stat
);

    localparam int PW    = $clog2(NUM_PAGES);
    localparam int CW    = $clog2(NUM_PAGES + 1);
    localparam int AW    = PW + SLOT_W;
    localparam int DEPTH = NUM_PAGES * ENTRIES;

    logic [FRAME_W-1:0] base_reg;
    logic [CW-1:0]      alloc_reg;
    logic [PW-1:0]      kidx_reg;
    logic               kvalid_reg;
    logic [PW-1:0]      new_page_reg;
    logic [PW-1:0]      cur_reg;
    logic [1:0]         level_reg;
    logic [SLOT_W-1:0]  cnt_reg;
    logic [1:0]         status_reg;
    logic               out_valid_reg;

    logic [1:0]         op_reg;
    logic [5:0]         root_reg;
    logic [VPN_W-1:0]   vpn_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               user_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [PW-1:0]      pidx_reg;
    logic [ENTRY_W-1:0] leaf_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    out_item_t          out_reg;

    logic [ENTRY_W-1:0] mem [DEPTH];

    logic [ENTRY_W-1:0] flags;
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] new_frame;
    logic [ENTRY_W-1:0] link_entry;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [FRAME_W-1:0] rel;
    logic [AW-1:0]      addr;
    logic [ENTRY_W-1:0] wdata;
    logic               cfg_write;

    // entry flags and level slot
    assign flags = FLAG_P | FLAG_W | (user_reg ? FLAG_U : '0);

    always_comb
    begin
        case (level_reg)
            2'd0:    slot = vpn_reg[8:0];
            2'd1:    slot = vpn_reg[17:9];
            2'd2:    slot = vpn_reg[26:18];
            default: slot = vpn_reg[35:27];
        endcase
    end

    // entry forming and link check
    assign new_frame  = base_reg + FRAME_W'(alloc_reg);
    assign link_entry = {new_frame, PAGE_SHIFT'(0)} | flags;
    assign leaf_entry = {frame_reg, PAGE_SHIFT'(0)} | flags;
    assign rel        = entry_reg[ENTRY_W-1:PAGE_SHIFT] - base_reg;

    // memory address and write data
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_WALK: addr = {cur_reg, slot};
            ADDR_NEW:  addr = {new_page_reg, cnt_reg};
            default:   addr = {kidx_reg, cnt_reg};
        endcase
    end

    always_comb
    begin
        case (cmd.wdata_sel)
            WD_ZERO: wdata = '0;
            WD_LINK: wdata = link_entry;
            WD_LEAF: wdata = leaf_entry;
            default: wdata = rdata_reg;
        endcase
    end

    // table memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.op        = op_reg;
        stat.root_bad  = 32'(root_reg) >= 32'(alloc_reg);
        stat.pool_full = 32'(alloc_reg) >= NUM_PAGES;
        stat.kroot_bad = !kvalid_reg || (32'(kidx_reg) >= 32'(alloc_reg));
        stat.present   = rdata_reg[0];
        stat.link_bad  = rel >= FRAME_W'(alloc_reg);
        stat.cnt_last  = cnt_reg == SLOT_W'(ENTRIES - 1);
        stat.level_one = level_reg == 2'd1;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // config port
    assign cfg_write = psel && penable && pwrite && (paddr[3] == REG_POOL_BASE);
    assign pready    = 1'b1;
    assign prdata    = (paddr[3] == REG_POOL_BASE) ? 64'(base_reg) : '0;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            alloc_reg     <= '0;
            kidx_reg      <= '0;
            kvalid_reg    <= 1'b0;
            new_page_reg  <= '0;
            cur_reg       <= '0;
            level_reg     <= '0;
            cnt_reg       <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                base_reg <= pwdata[FRAME_W-1:0];
            end
            if (cmd.alloc)
            begin
                new_page_reg <= alloc_reg[PW-1:0];
                alloc_reg    <= alloc_reg + CW'(1);
            end
            if (cmd.set_kroot)
            begin
                kidx_reg   <= alloc_reg[PW-1:0];
                kvalid_reg <= 1'b1;
            end
            if (cmd.start_walk)
            begin
                cur_reg   <= PW'(root_reg);
                level_reg <= 2'd3;
            end
            else if (cmd.step)
            begin
                cur_reg   <= rel[PW-1:0];
                level_reg <= level_reg - 2'd1;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + SLOT_W'(1);
            end
            if (cmd.load_item)
            begin
                status_reg <= ST_OK;
            end
            else if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= in_data.op;
            root_reg  <= in_data.root_page;
            vpn_reg   <= in_data.virtual_page;
            frame_reg <= in_data.frame;
            user_reg  <= in_data.user;
            pidx_reg  <= '0;
            leaf_reg  <= '0;
        end
        else
        begin
            if (cmd.use_fresh)
            begin
                frame_reg <= new_frame;
                user_reg  <= 1'b1;
            end
            if (cmd.set_pidx)
            begin
                pidx_reg <= alloc_reg[PW-1:0];
            end
            if (cmd.set_leaf)
            begin
                leaf_reg <= leaf_entry;
            end
        end
        if (cmd.entry_from_mem)
        begin
            entry_reg <= rdata_reg;
        end
        else if (cmd.entry_from_link)
        begin
            entry_reg <= link_entry;
        end
        if (cmd.emit)
        begin
            out_reg.status     <= status_reg;
            out_reg.page_index <= (status_reg == ST_OK) ? 6'(pidx_reg) : '0;
            out_reg.leaf_entry <= (status_reg == ST_OK) ? leaf_reg : '0;
            out_reg.pages_used <= 7'(alloc_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

@@ hw/rtl/ptm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_ctrl
// Sequencer for walks, page clears, root clones and result transfer.
// ----------------------------------------------------------------------------
module ptm_ctrl
    import ptm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CLEAR,
        S_RD,
        S_RDW,
        S_LINK,
        S_LEAF,
        S_COPY_RD,
        S_COPY_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        R_WALK,
        R_LINK,
        R_DONE
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    // state and return point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= R_DONE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (stat.op)
                    OP_MAP:
                    begin
                        if (stat.root_bad)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_BAD;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = S_RD;
                        end
                    end
                    OP_MAP_FRESH:
                    begin
                        if (stat.root_bad)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_BAD;
                            state_next      = S_DONE;
                        end
                        else if (stat.pool_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOMEM;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.alloc     = 1'b1;
                            cmd.use_fresh = 1'b1;
                            cmd.set_pidx  = 1'b1;
                            cmd.cnt_clr   = 1'b1;
                            ret_next      = R_WALK;
                            state_next    = S_CLEAR;
                        end
                    end
                    OP_KROOT:
                    begin
                        if (stat.pool_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOMEM;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.alloc     = 1'b1;
                            cmd.set_kroot = 1'b1;
                            cmd.set_pidx  = 1'b1;
                            cmd.cnt_clr   = 1'b1;
                            ret_next      = R_DONE;
                            state_next    = S_CLEAR;
                        end
                    end
                    default:
                    begin
                        if (stat.kroot_bad)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_BAD;
                            state_next      = S_DONE;
                        end
                        else if (stat.pool_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_NOMEM;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.alloc    = 1'b1;
                            cmd.set_pidx = 1'b1;
                            cmd.cnt_clr  = 1'b1;
                            state_next   = S_COPY_RD;
                        end
                    end
                endcase
            end
            // zero a freshly allocated page, one entry a cycle
            S_CLEAR:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.addr_sel  = ADDR_NEW;
                cmd.wdata_sel = WD_ZERO;
                cmd.cnt_inc   = 1'b1;
                if (stat.cnt_last)
                begin
                    case (ret_reg)
                        R_WALK:
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = S_RD;
                        end
                        R_LINK:  state_next = S_LINK;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_WALK;
                state_next   = S_RDW;
            end
            // follow a present entry or create the missing table
            S_RDW:
            begin
                if (stat.present)
                begin
                    cmd.entry_from_mem = 1'b1;
                    state_next         = S_LINK;
                end
                else if (stat.pool_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOMEM;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.alloc           = 1'b1;
                    cmd.mem_wr          = 1'b1;
                    cmd.addr_sel        = ADDR_WALK;
                    cmd.wdata_sel       = WD_LINK;
                    cmd.entry_from_link = 1'b1;
                    cmd.cnt_clr         = 1'b1;
                    ret_next            = R_LINK;
                    state_next          = S_CLEAR;
                end
            end
            S_LINK:
            begin
                if (stat.link_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_BAD;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = stat.level_one ? S_LEAF : S_RD;
                end
            end
            S_LEAF:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.addr_sel  = ADDR_WALK;
                cmd.wdata_sel = WD_LEAF;
                cmd.set_leaf  = 1'b1;
                state_next    = S_DONE;
            end
            // copy kernel root entries into the new root
            S_COPY_RD:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_KROOT;
                state_next   = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.addr_sel  = ADDR_NEW;
                cmd.wdata_sel = WD_COPY;
                cmd.cnt_inc   = 1'b1;
                state_next    = stat.cnt_last ? S_DONE : S_COPY_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
